[src/ddsa_pkg.sv]
// Shared types and constants for the decimal digit sequence adder.
`default_nettype none
package ddsa_pkg;

	localparam int DIGIT_W = 4;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam logic [DIGIT_W:0] DEC_BASE = 5'd10;

	// One classified beat passed from the front queue to the back end.
	typedef struct packed {
		logic               is_second;
		logic [DIGIT_W-1:0] digit;
		logic               is_last;
	} cmd_t;

endpackage
`default_nettype wire

[src/ddsa_front.sv]
// Front end: accepts input beats, clamps the digit and queues them for the back end.
`default_nettype none
module ddsa_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              req_type,
	input  wire logic [ddsa_pkg::DIGIT_W-1:0]      digit,
	input  wire logic                              is_last,
	output logic                                   cmd_valid,
	output ddsa_pkg::cmd_t                         cmd,
	input  wire logic                              cmd_pop
);

	ddsa_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	ddsa_pkg::cmd_t in_cmd;
	logic           do_push;
	logic           do_pop;

	always_comb begin
		in_cmd.is_second = req_type;
		in_cmd.digit     = (digit > ddsa_pkg::DIGIT_MAX) ? ddsa_pkg::DIGIT_MAX : digit;
		in_cmd.is_last   = is_last;
	end

	assign full      = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[src/ddsa_back.sv]
// Back end: digit stacks, decimal add from the low end, and most-significant-first readout.
`default_nettype none
module ddsa_back #(
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	input  wire ddsa_pkg::cmd_t                    cmd,
	output logic                                   cmd_pop,
	output logic                                   out_valid,
	output logic [ddsa_pkg::DIGIT_W-1:0]           out_digit,
	output logic                                   out_final,
	output logic                                   out_ovf,
	input  wire logic                              out_pop
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD_RD = 3'd1;
	localparam logic [2:0] ST_ADD_WR = 3'd2;
	localparam logic [2:0] ST_FIN    = 3'd3;
	localparam logic [2:0] ST_EM_RD  = 3'd4;
	localparam logic [2:0] ST_EM_WR  = 3'd5;

	logic [ddsa_pkg::DIGIT_W-1:0] first_mem  [MAX_DIGITS];
	logic [ddsa_pkg::DIGIT_W-1:0] second_mem [MAX_DIGITS];
	logic [ddsa_pkg::DIGIT_W-1:0] sum_mem    [MAX_DIGITS+1];

	logic [2:0]                   state_q;
	logic [CNT_W-1:0]             fcnt_q;
	logic [CNT_W-1:0]             scnt_q;
	logic                         drop_q;
	logic [CNT_W-1:0]             i_q;
	logic [CNT_W-1:0]             len_q;
	logic                         carry_q;
	logic [CNT_W-1:0]             j_q;

	logic [ddsa_pkg::DIGIT_W-1:0] rd_a_s1;
	logic [ddsa_pkg::DIGIT_W-1:0] rd_b_s1;
	logic                         a_ok_s1;
	logic                         b_ok_s1;
	logic [ddsa_pkg::DIGIT_W-1:0] rd_sum_q;

	logic                         out_valid_q;
	logic [ddsa_pkg::DIGIT_W-1:0] out_digit_q;
	logic                         out_final_q;
	logic                         out_ovf_q;

	logic                         take;
	logic                         f_room;
	logic                         s_room;
	logic [CNT_W-1:0]             scnt_nx;
	logic [CNT_W-1:0]             a_addr;
	logic [CNT_W-1:0]             b_addr;
	logic                         a_ok;
	logic                         b_ok;
	logic [ddsa_pkg::DIGIT_W-1:0] a_val;
	logic [ddsa_pkg::DIGIT_W-1:0] b_val;
	logic [ddsa_pkg::DIGIT_W:0]   sum5;
	logic [ddsa_pkg::DIGIT_W:0]   sum5_adj;
	logic                         ge;
	logic [ddsa_pkg::DIGIT_W-1:0] sum_dig;
	logic [CNT_W-1:0]             i_nx;
	logic                         ld_out;

	assign take    = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_pop = take;
	assign f_room  = (fcnt_q < MAX_CNT);
	assign s_room  = (scnt_q < MAX_CNT);
	assign scnt_nx = s_room ? (scnt_q + ONE) : scnt_q;

	// Stacks are read top-down: entry i from the low end sits at count-1-i.
	assign a_ok   = (i_q < fcnt_q);
	assign b_ok   = (i_q < scnt_q);
	assign a_addr = a_ok ? (fcnt_q - ONE - i_q) : '0;
	assign b_addr = b_ok ? (scnt_q - ONE - i_q) : '0;

	assign a_val    = a_ok_s1 ? rd_a_s1 : '0;
	assign b_val    = b_ok_s1 ? rd_b_s1 : '0;
	assign sum5     = {1'b0, a_val} + {1'b0, b_val} + {{ddsa_pkg::DIGIT_W{1'b0}}, carry_q};
	assign ge       = (sum5 >= ddsa_pkg::DEC_BASE);
	assign sum5_adj = sum5 - ddsa_pkg::DEC_BASE;
	assign sum_dig  = ge ? sum5_adj[ddsa_pkg::DIGIT_W-1:0] : sum5[ddsa_pkg::DIGIT_W-1:0];
	assign i_nx     = i_q + ONE;

	assign ld_out = (state_q == ST_EM_WR) && (!out_valid_q || out_pop);

	// Storage and read data
	always_ff @(posedge clk) begin
		if (take && !cmd.is_second && f_room) begin
			first_mem[fcnt_q[IDX_W-1:0]] <= cmd.digit;
		end
		if (take && cmd.is_second && s_room) begin
			second_mem[scnt_q[IDX_W-1:0]] <= cmd.digit;
		end
		if (state_q == ST_ADD_RD) begin
			rd_a_s1 <= first_mem[a_addr[IDX_W-1:0]];
			rd_b_s1 <= second_mem[b_addr[IDX_W-1:0]];
			a_ok_s1 <= a_ok;
			b_ok_s1 <= b_ok;
		end
		if (state_q == ST_ADD_WR) begin
			sum_mem[i_q] <= sum_dig;
		end else if (state_q == ST_FIN && carry_q) begin
			sum_mem[len_q] <= {{(ddsa_pkg::DIGIT_W-1){1'b0}}, 1'b1};
		end
		if (state_q == ST_EM_RD) begin
			rd_sum_q <= sum_mem[j_q];
		end
		if (ld_out) begin
			out_digit_q <= rd_sum_q;
			out_final_q <= (j_q == '0);
			out_ovf_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fcnt_q      <= '0;
			scnt_q      <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			len_q       <= '0;
			carry_q     <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (!cmd.is_second) begin
							if (f_room) begin
								fcnt_q <= fcnt_q + ONE;
							end else begin
								drop_q <= 1'b1;
							end
						end else begin
							scnt_q <= scnt_nx;
							if (!s_room) begin
								drop_q <= 1'b1;
							end
							if (cmd.is_last) begin
								len_q   <= (fcnt_q > scnt_nx) ? fcnt_q : scnt_nx;
								i_q     <= '0;
								carry_q <= 1'b0;
								state_q <= ST_ADD_RD;
							end
						end
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WR;
				end
				ST_ADD_WR: begin
					carry_q <= ge;
					i_q     <= i_nx;
					state_q <= (i_nx == len_q) ? ST_FIN : ST_ADD_RD;
				end
				ST_FIN: begin
					// A leftover carry adds one leading digit.
					j_q     <= carry_q ? len_q : (len_q - ONE);
					state_q <= ST_EM_RD;
				end
				ST_EM_RD: begin
					state_q <= ST_EM_WR;
				end
				ST_EM_WR: begin
					if (ld_out) begin
						if (j_q == '0) begin
							fcnt_q  <= '0;
							scnt_q  <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q - ONE;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_digit = out_digit_q;
	assign out_final = out_final_q;
	assign out_ovf   = out_ovf_q;

endmodule
`default_nettype wire

[src/decimal_digit_sequence_adder_unit.sv]
// Top level of the decimal digit sequence adder: front queue plus back end.
// A digit beat is written to its stack, if it has room, when the back end takes it from the queue. The
// second operand's last digit starts the add: a read state and a write state per digit for L
// digits (L = digits of the longer operand), then sum beats are read out while pop keeps up.
// Throughput: 1 beat per cycle into a 2-beat queue while the back end is idle.
// Reset clears counts, flags, queue and output valid; the digit stores keep their contents.
`default_nettype none
module decimal_digit_sequence_adder_unit #(
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          req_type,
	input  wire logic [ddsa_pkg::DIGIT_W-1:0]  digit,
	input  wire logic                          is_last,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [ddsa_pkg::DIGIT_W-1:0]       sum_digit,
	output logic                               final_digit,
	output logic                               overflowed
);

	logic           cmd_valid;
	ddsa_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           out_valid;

	ddsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.digit     (digit),
		.is_last   (is_last),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ddsa_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_digit (sum_digit),
		.out_final (final_digit),
		.out_ovf   (overflowed),
		.out_pop   (pop)
	);

	assign empty = !out_valid;

endmodule
`default_nettype wire
